// File: hw/rtl/ncc_pkg.sv
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared types and constants for the nearest centroid classifier.
// ----------------------------------------------------------------------------
package ncc_pkg;

    localparam int COORD_BITS     = 16;
    localparam int MAX_DIMS       = 8;
    localparam int ROW_SEL_BITS   = 4;
    localparam int LABEL_BITS     = 4;
    localparam int DIST_BITS      = 35;
    localparam int MAG_BITS       = COORD_BITS;
    localparam int SQ_BITS        = 2 * COORD_BITS;
    localparam int CLUSTERS_BITS  = 5;
    localparam int DIMS_BITS      = 4;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 5;
    localparam int ROW_BITS       = MAX_DIMS * COORD_BITS;

    // opcodes
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLUSTERS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIMS_IN_USE     = 2'd1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [ROW_BITS-1:0]          row_bits_t;

    typedef struct packed {
        logic                    opcode;
        logic [ROW_SEL_BITS-1:0] row_select;
        coord_t                  coord0;
        coord_t                  coord1;
        coord_t                  coord2;
        coord_t                  coord3;
        coord_t                  coord4;
        coord_t                  coord5;
        coord_t                  coord6;
        coord_t                  coord7;
    } in_item_t;

    typedef struct packed {
        logic [LABEL_BITS-1:0] best_label;
        logic [DIST_BITS-1:0]  best_distance_sq;
    } out_item_t;

    // coordinate d sits at bits [d*COORD_BITS +: COORD_BITS]
    function automatic row_bits_t pack_row(in_item_t item);
        return {item.coord7, item.coord6, item.coord5, item.coord4,
                item.coord3, item.coord2, item.coord1, item.coord0};
    endfunction

endpackage

// File: hw/rtl/ncc_ram.sv
// ----------------------------------------------------------------------------
// ncc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ncc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/nearest_centroid_classifier_unit.sv
// ----------------------------------------------------------------------------
// nearest_centroid_classifier_unit
// Nearest-centroid assignment: finds the stored centroid row closest to a
// point in squared Euclidean distance, lowest index on ties.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                          | Direction | Moves
//  --------+--------------------------------+-----------+---------------------
//  s_      | s_valid s_ready s_data         | in        | load row / classify
//  m_      | m_valid m_ready m_data         | out       | label + distance
//  cfg_    | cfg_we cfg_index cfg_wdata     | in        | register write
//
//  A load transaction writes the row to the centroid RAM at the accepting
//  edge. A classify reads N rows, N = clamped clusters_in_use; the single RAM
//  read port delivers one row per cycle into a three-stage pipe (squares,
//  sum, compare), then the result is published through the output register.
//  aresetn (synchronous, active low) clears control and config; the centroid
//  RAM holds garbage until rows are loaded. A result waiting on m_ready does
//  not block the next accept; a classify that finishes while that result is
//  still held waits in its final state.
// ----------------------------------------------------------------------------
module nearest_centroid_classifier_unit
    import ncc_pkg::*;
#(
    parameter int MAX_CLUSTERS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_item_t                 s_data,

    output logic                     m_valid,
    input  logic                     m_ready,
    output out_item_t                m_data,

    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    localparam int AW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

    typedef logic [AW-1:0] label_t;

    typedef enum logic [1:0] {
        ST_IDLE,    // waiting for a transaction
        ST_RUN,     // issuing row reads
        ST_DRAIN,   // reads issued, pipe emptying
        ST_FINISH   // best result ready, waiting for output slot
    } state_t;

    state_t state_reg;

    // config
    logic [CLUSTERS_BITS-1:0] clusters_reg;
    logic [DIMS_BITS-1:0]     dims_reg;

    // per-classify context
    row_bits_t              point_reg;
    label_t                 last_k_reg;
    logic [MAX_DIMS-1:0]    lane_en_reg;
    label_t                 k_reg;

    label_t                 last_k_next;
    logic [MAX_DIMS-1:0]    lane_en_next;

    // output register
    logic                   m_valid_reg;
    out_item_t              m_data_reg;

    // RAM
    logic                   ram_we;
    logic                   ram_re;
    row_bits_t              ram_rdata;
    logic                   s_accept;
    logic                   row_ok;

    // pipe: stage 1 = RAM output, stage 2 = squares, stage 3 = sum
    logic                   rd_valid_reg;
    label_t                 rd_label_reg;
    logic                   sq_valid_reg;
    label_t                 sq_label_reg;
    logic [SQ_BITS-1:0]     sq_reg   [MAX_DIMS];
    logic [SQ_BITS-1:0]     sq_next  [MAX_DIMS];
    logic                   sum_valid_reg;
    label_t                 sum_label_reg;
    logic [DIST_BITS-1:0]   sum_reg;
    logic [DIST_BITS-1:0]   sum_next;

    // running best
    logic [DIST_BITS-1:0]   best_dist_reg;
    label_t                 best_label_reg;
    logic                   take_new;
    logic                   last_row_done;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // loads to rows beyond the table are dropped
    assign row_ok = (32'(s_data.row_select) < MAX_CLUSTERS);
    assign ram_we = s_accept && (s_data.opcode == OP_LOAD) && row_ok;
    assign ram_re = (state_reg == ST_RUN);

    ncc_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (MAX_CLUSTERS)
    ) u_centroid_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(s_data.row_select)),
        .wdata (pack_row(s_data)),
        .re    (ram_re),
        .raddr (k_reg),
        .rdata (ram_rdata)
    );

    // clamp counts: 0 acts as 1, above the maximum acts as the maximum
    always_comb begin
        int nk;
        int nd;
        nk = int'(clusters_reg);
        nd = int'(dims_reg);
        if (nk == 0) begin
            last_k_next = '0;
        end else if (nk > MAX_CLUSTERS) begin
            last_k_next = AW'(MAX_CLUSTERS - 1);
        end else begin
            last_k_next = AW'(nk - 1);
        end
        if (nd == 0) begin
            nd = 1;
        end else if (nd > MAX_DIMS) begin
            nd = MAX_DIMS;
        end
        for (int d = 0; d < MAX_DIMS; d++) begin
            lane_en_next[d] = (d < nd);
        end
    end

    // per-lane squared difference; lanes above dims_in_use contribute zero
    always_comb begin
        logic signed [COORD_BITS:0] diff;
        logic        [COORD_BITS:0] mag;
        for (int d = 0; d < MAX_DIMS; d++) begin
            diff = $signed({point_reg[d*COORD_BITS + COORD_BITS-1],
                            point_reg[d*COORD_BITS +: COORD_BITS]})
                 - $signed({ram_rdata[d*COORD_BITS + COORD_BITS-1],
                            ram_rdata[d*COORD_BITS +: COORD_BITS]});
            mag  = diff[COORD_BITS] ? (COORD_BITS+1)'(-diff) : diff;
            if (lane_en_reg[d]) begin
                sq_next[d] = SQ_BITS'(mag[MAG_BITS-1:0]) * SQ_BITS'(mag[MAG_BITS-1:0]);
            end else begin
                sq_next[d] = '0;
            end
        end
    end

    always_comb begin
        sum_next = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            sum_next = sum_next + DIST_BITS'(sq_reg[d]);
        end
    end

    // row 0 always seeds; strict less-than keeps the lowest index on ties
    assign take_new      = sum_valid_reg &&
                           ((sum_label_reg == '0) || (sum_reg < best_dist_reg));
    assign last_row_done = sum_valid_reg && (sum_label_reg == last_k_reg);

    // pipe datapath
    always_ff @(posedge aclk) begin
        rd_label_reg  <= k_reg;
        sq_label_reg  <= rd_label_reg;
        sum_label_reg <= sq_label_reg;
        for (int d = 0; d < MAX_DIMS; d++) begin
            sq_reg[d] <= sq_next[d];
        end
        sum_reg <= sum_next;
        if (take_new) begin
            best_dist_reg  <= sum_reg;
            best_label_reg <= sum_label_reg;
        end
        if (!aresetn) begin
            rd_valid_reg  <= 1'b0;
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg  <= ram_re;
            sq_valid_reg  <= rd_valid_reg;
            sum_valid_reg <= sq_valid_reg;
        end
    end

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clusters_reg <= CLUSTERS_BITS'(16);
            dims_reg     <= DIMS_BITS'(8);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CLUSTERS_IN_USE: clusters_reg <= cfg_wdata[CLUSTERS_BITS-1:0];
                CFG_DIMS_IN_USE:     dims_reg     <= cfg_wdata[DIMS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
        end else begin
            // publish from the final state, else drop valid once taken
            if ((state_reg == ST_FINISH) && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept && (s_data.opcode == OP_CLASSIFY)) begin
                        point_reg   <= pack_row(s_data);
                        last_k_reg  <= last_k_next;
                        lane_en_reg <= lane_en_next;
                        k_reg       <= '0;
                        state_reg   <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (k_reg == last_k_reg) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (last_row_done) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.best_label       <= LABEL_BITS'(best_label_reg);
                        m_data_reg.best_distance_sq <= best_dist_reg;
                        state_reg                   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: tb/sv/nearest_centroid_classifier_unit_tb.sv
// ----------------------------------------------------------------------------
// nearest_centroid_classifier_unit_tb
// Self-checking bench: loads centroid rows, classifies points and compares
// every label and squared distance against an in-bench scoreboard model.
// ----------------------------------------------------------------------------
module nearest_centroid_classifier_unit_tb;
    import ncc_pkg::*;

    localparam int NUM_ROWS       = 16;
    localparam int IDLE_PCT       = 13;      // idle / stall odds per cycle, percent
    localparam int SETTLE_CYCLES  = 32;      // outlasts any classify, N <= 16
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int REPORT_LIMIT   = 10;

    // indexes past the register list; writes there must be ignored
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_3 = 2'd3;

    // ------------------------------------------------------------------
    // clock, reset, DUT ports
    // ------------------------------------------------------------------
    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    in_item_t                 s_data    = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    out_item_t                m_data;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    nearest_centroid_classifier_unit #(
        .MAX_CLUSTERS(NUM_ROWS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // scoreboard state: own copy of the centroid rows and both registers
    // ------------------------------------------------------------------
    coord_t                   centroid_rows [NUM_ROWS][MAX_DIMS];
    logic [CLUSTERS_BITS-1:0] clusters_reg = 5'd16;   // reset values
    logic [DIMS_BITS-1:0]     dims_reg     = 4'd8;
    out_item_t                pending_results[$];
    out_item_t                oldest_result;

    int  mismatches    = 0;
    int  items_sent    = 0;
    int  loads_sent    = 0;
    int  results_seen  = 0;
    int  reg_writes    = 0;
    int  cycle_count   = 0;
    bit  sender_gaps_on     = 1'b1;
    bit  receiver_stalls_on = 1'b1;

    function automatic coord_t coord_at(in_item_t it, int d);
        case (d)
            0:       return it.coord0;
            1:       return it.coord1;
            2:       return it.coord2;
            3:       return it.coord3;
            4:       return it.coord4;
            5:       return it.coord5;
            6:       return it.coord6;
            default: return it.coord7;
        endcase
    endfunction

    // Nearest row over the active rows and coordinates. Counts of zero act as
    // one, counts above the table size act as the table size. Strict less-than
    // keeps the lowest index on a tie.
    function automatic out_item_t nearest_centroid(in_item_t pt);
        int                 n_rows;
        int                 n_dims;
        int                 best_row;
        longint             diff;
        longint unsigned    mag;
        longint unsigned    sum_sq;
        longint unsigned    best_sum;
        out_item_t          res;
        n_rows   = (clusters_reg == 0) ? 1 :
                   (int'(clusters_reg) > NUM_ROWS) ? NUM_ROWS : int'(clusters_reg);
        n_dims   = (dims_reg == 0) ? 1 :
                   (int'(dims_reg) > MAX_DIMS) ? MAX_DIMS : int'(dims_reg);
        best_row = 0;
        best_sum = 0;
        for (int k = 0; k < n_rows; k++) begin
            sum_sq = 0;
            for (int d = 0; d < n_dims; d++) begin
                diff   = longint'(coord_at(pt, d)) - longint'(centroid_rows[k][d]);
                mag    = (diff < 0) ? -diff : diff;
                sum_sq += mag * mag;
            end
            if (k == 0 || sum_sq < best_sum) begin
                best_sum = sum_sq;
                best_row = k;
            end
        end
        res.best_label       = best_row[LABEL_BITS-1:0];
        res.best_distance_sq = best_sum[DIST_BITS-1:0];
        return res;
    endfunction

    // Called at the accepting edge: loads update the rows, classifies queue
    // their expected result.
    task automatic absorb_item(input in_item_t it);
        if (it.opcode == OP_LOAD) begin
            for (int d = 0; d < MAX_DIMS; d++)
                centroid_rows[it.row_select][d] = coord_at(it, d);
            loads_sent++;
        end else begin
            pending_results.push_back(nearest_centroid(it));
        end
        items_sent++;
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic coord_t pick_coord(bit narrow);
        if (narrow)
            return coord_t'(int'($urandom_range(8)) - 4);
        if ($urandom_range(99) < 10) begin
            case ($urandom_range(5))
                0:       return coord_t'(16'sh8000);
                1:       return coord_t'(16'sh8001);
                2:       return coord_t'(-1);
                3:       return coord_t'(0);
                4:       return coord_t'(1);
                default: return coord_t'(16'sh7FFF);
            endcase
        end
        return coord_t'($urandom);
    endfunction

    function automatic in_item_t random_item(logic op, bit narrow);
        in_item_t it;
        it.opcode     = op;
        it.row_select = ROW_SEL_BITS'($urandom_range(NUM_ROWS - 1));
        it.coord0     = pick_coord(narrow);
        it.coord1     = pick_coord(narrow);
        it.coord2     = pick_coord(narrow);
        it.coord3     = pick_coord(narrow);
        it.coord4     = pick_coord(narrow);
        it.coord5     = pick_coord(narrow);
        it.coord6     = pick_coord(narrow);
        it.coord7     = pick_coord(narrow);
        return it;
    endfunction

    function automatic in_item_t uniform_item(logic op, int row, coord_t v);
        in_item_t it;
        it.opcode     = op;
        it.row_select = row[ROW_SEL_BITS-1:0];
        it.coord0     = v;
        it.coord1     = v;
        it.coord2     = v;
        it.coord3     = v;
        it.coord4     = v;
        it.coord5     = v;
        it.coord6     = v;
        it.coord7     = v;
        return it;
    endfunction

    // Sends one transaction. Leaves s_valid high at the accepting edge so a
    // back-to-back item needs no drop; callers end a burst with release_bus.
    task automatic send_item(input in_item_t it);
        while (sender_gaps_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        absorb_item(it);
    endtask

    task automatic release_bus();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_results();
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Quiesce before any register write: loads give no result, so a trailing
    // classify may still be running after the queue empties.
    task automatic drain();
        release_bus();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_CLUSTERS_IN_USE)
            clusters_reg = data[CLUSTERS_BITS-1:0];
        else if (idx == CFG_DIMS_IN_USE)
            dims_reg = data[DIMS_BITS-1:0];
        reg_writes++;
    endtask

    task automatic set_sizes(input logic [CFG_DATA_BITS-1:0] clusters,
                             input logic [CFG_DATA_BITS-1:0] dims);
        drain();
        write_reg(CFG_CLUSTERS_IN_USE, clusters);
        write_reg(CFG_DIMS_IN_USE, dims);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // Fill every row so no classify can ever touch an unwritten row.
    // Rows 0..2 hold the coordinate extremes and zero; row 9 copies row 5.
    task automatic test_load_rows();
        in_item_t row_five;
        in_item_t it;
        for (int r = 0; r < NUM_ROWS; r++) begin
            case (r)
                0:       it = uniform_item(OP_LOAD, r, coord_t'(16'sh8000));
                1:       it = uniform_item(OP_LOAD, r, coord_t'(16'sh7FFF));
                2:       it = uniform_item(OP_LOAD, r, coord_t'(0));
                9: begin
                    it            = row_five;
                    it.row_select = 4'd9;
                end
                default: it = random_item(OP_LOAD, 1'b0);
            endcase
            it.row_select = r[ROW_SEL_BITS-1:0];
            if (r == 5)
                row_five = it;
            send_item(it);
        end
        // classify the copied row: distance zero to rows 5 and 9, row 5 wins
        it        = row_five;
        it.opcode = OP_CLASSIFY;
        send_item(it);
    endtask

    // Reset values of both registers are in force here (no write yet).
    task automatic test_extreme_points();
        in_item_t it;
        send_item(uniform_item(OP_CLASSIFY, 15, coord_t'(16'sh7FFF)));
        send_item(uniform_item(OP_CLASSIFY, 0, coord_t'(16'sh8000)));
        send_item(uniform_item(OP_CLASSIFY, 7, coord_t'(0)));
        it        = uniform_item(OP_CLASSIFY, 10, coord_t'(16'sh7FFF));
        it.coord1 = coord_t'(16'sh8000);
        it.coord3 = coord_t'(16'sh8000);
        it.coord5 = coord_t'(16'sh8000);
        it.coord7 = coord_t'(16'sh8000);
        send_item(it);
    endtask

    // One row (all -32768) against a point of all +32767: largest distance.
    task automatic test_max_distance();
        set_sizes(5'd1, 5'd8);
        send_item(uniform_item(OP_CLASSIFY, 3, coord_t'(16'sh7FFF)));
        send_item(uniform_item(OP_CLASSIFY, 3, coord_t'(16'sh8000)));
        set_sizes(5'd2, 5'd1);
        send_item(uniform_item(OP_CLASSIFY, 6, coord_t'(16'sh7FFF)));
    endtask

    // Zero counts act as one, oversize counts clamp, the dims write keeps
    // only four bits, and writes past the register list change nothing.
    task automatic test_register_limits();
        set_sizes(5'd0, 5'd0);
        send_item(random_item(OP_CLASSIFY, 1'b0));
        set_sizes(5'd31, 5'd15);
        send_item(random_item(OP_CLASSIFY, 1'b0));
        set_sizes(5'd16, 5'd16);
        send_item(random_item(OP_CLASSIFY, 1'b0));
        drain();
        write_reg(CFG_UNUSED_2, 5'($urandom));
        write_reg(CFG_UNUSED_3, 5'($urandom));
        send_item(random_item(OP_CLASSIFY, 1'b0));
    endtask

    // Random mix of row loads and classifies under one register setting.
    // With hold_midway set the sender stops half way until the result queue
    // is empty, then resumes.
    task automatic random_phase(input int n_items,
                                input logic [CFG_DATA_BITS-1:0] clusters,
                                input logic [CFG_DATA_BITS-1:0] dims,
                                input bit narrow, input bit quiet,
                                input bit hold_midway);
        set_sizes(clusters, dims);
        sender_gaps_on     = !quiet;
        receiver_stalls_on = !quiet;
        for (int i = 0; i < n_items; i++) begin
            if (hold_midway && i == n_items / 2) begin
                release_bus();
                wait_results();
            end
            send_item(random_item(($urandom_range(99) < 30) ? OP_LOAD : OP_CLASSIFY,
                                  narrow));
        end
        drain();
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
    endtask

    task automatic test_random_full();
        random_phase(90, 5'd16, 5'd8, 1'b0, 1'b0, 1'b1);
    endtask

    // small coordinate spread makes ties common
    task automatic test_random_ties();
        random_phase(80, 5'($urandom_range(16, 1)), 5'($urandom_range(8, 1)),
                     1'b1, 1'b0, 1'b0);
    endtask

    // back-to-back transactions, no gaps on either side
    task automatic test_random_streaming();
        random_phase(80, 5'd16, 5'd8, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_random_sweep();
        random_phase(50, 5'd1, 5'd1, 1'b0, 1'b0, 1'b0);
        for (int p = 0; p < 3; p++)
            random_phase(50, 5'($urandom), 5'($urandom), p[0], 1'b0, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // result side: random back-pressure and the in-order checker
    // ------------------------------------------------------------------
    always @(posedge aclk)
        m_ready <= !receiver_stalls_on || ($urandom_range(99) >= IDLE_PCT);

    task automatic report_mismatch(input string field,
                                   input logic [63:0] want,
                                   input logic [63:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] mismatch on %s: expected %0d, got %0d",
                     $realtime, field, want, got);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result (label)", '0,
                                64'(m_data.best_label));
            end else begin
                oldest_result = pending_results.pop_front();
                results_seen++;
                if (m_data.best_label !== oldest_result.best_label)
                    report_mismatch("best_label", 64'(oldest_result.best_label),
                                    64'(m_data.best_label));
                if (m_data.best_distance_sq !== oldest_result.best_distance_sq)
                    report_mismatch("best_distance_sq",
                                    64'(oldest_result.best_distance_sq),
                                    64'(m_data.best_distance_sq));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_load_rows();
        test_extreme_points();
        test_max_distance();
        test_register_limits();
        test_random_full();
        test_random_ties();
        test_random_streaming();
        test_random_sweep();

        drain();
        $display("run: %0d transactions (%0d row loads), %0d results checked, %0d mismatches",
                 items_sent, loads_sent, results_seen, mismatches);
        $display("run: %0d register writes incl. zero, clamped and unused-index values",
                 reg_writes);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/ncc_pkg.sv
hw/rtl/ncc_ram.sv
hw/rtl/nearest_centroid_classifier_unit.sv
tb/sv/nearest_centroid_classifier_unit_tb.sv
